@@ rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes and score helpers shared by the transposition table blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int unsigned MATE_BAND  = 512;
  localparam int unsigned MATE_RESET = 32000;
  localparam int unsigned FIFO_DEPTH = 2;

  // APB register map (byte addresses)
  localparam int unsigned ADDR_W         = 3;
  localparam logic        REG_MATE_VALUE = 1'b0;  // paddr[2] selects register

  typedef enum logic [1:0] {
    BOUND_NONE  = 2'd0,
    BOUND_EXACT = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_UPPER = 2'd3
  } bound_t;

  // request handed from the front end to the back end
  typedef struct packed {
    logic        is_store;
    logic [63:0] key;
    logic [6:0]  depth;
    logic [7:0]  ply;
    logic [15:0] score;   // already ply-adjusted for stores
    logic [1:0]  bound;
    logic [31:0] move;
    logic [15:0] alpha;
    logic [15:0] beta;
  } req_t;

  // one table slot
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] move;
    logic [15:0] score;
    logic [6:0]  depth;
    logic [1:0]  bound;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Mate-distance adjustment, exact 18-bit result. Upper band wins when the
  // two bands overlap.
  function automatic logic signed [17:0] mate_adjust(
    input logic [15:0] score,
    input logic [7:0]  ply,
    input logic [14:0] mate,
    input logic        storing
  );
    logic signed [17:0] s;
    logic signed [17:0] p;
    logic signed [17:0] hi_thr;
    logic signed [17:0] lo_thr;
    logic signed [17:0] res;
    s      = 18'($signed(score));
    p      = $signed({10'd0, ply});
    hi_thr = $signed({3'd0, mate}) - 18'sd512;
    lo_thr = 18'sd512 - $signed({3'd0, mate});
    if (s >= hi_thr) begin
      res = storing ? s + p : s - p;
    end else if (s <= lo_thr) begin
      res = storing ? s - p : s + p;
    end else begin
      res = s;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/stt_fifo.sv @@
// ----------------------------------------------------------------------------
// stt_fifo
// Short request queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire stt_pkg::req_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output logic               not_empty,
  output stt_pkg::req_t      rd_data
);

  localparam int unsigned PTR_W = $clog2(stt_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(stt_pkg::FIFO_DEPTH + 1);

  stt_pkg::req_t    slots [stt_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(stt_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(stt_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(stt_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/stt_front.sv @@
// ----------------------------------------------------------------------------
// stt_front
// Accepts requests, classifies probe/store, applies store-side mate
// adjustment and queues the request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front (
  input  wire logic          push,
  output logic               full,
  input  wire logic          mode,
  input  wire logic [63:0]   key,
  input  wire logic [6:0]    depth,
  input  wire logic [7:0]    ply,
  input  wire logic [15:0]   score_in,
  input  wire logic [1:0]    bound_kind,
  input  wire logic [31:0]   move,
  input  wire logic [15:0]   alpha,
  input  wire logic [15:0]   beta,
  input  wire logic [14:0]   mate_value,
  input  wire logic          busy,      // table clear in progress
  input  wire logic          q_full,
  output logic               q_wr,
  output stt_pkg::req_t      q_data
);

  logic signed [17:0] adj;

  assign full = q_full || busy;
  assign q_wr = push && !full;

  assign adj = stt_pkg::mate_adjust(score_in, ply, mate_value, 1'b1);

  always_comb begin
    q_data.is_store = mode;
    q_data.key      = key;
    q_data.depth    = depth;
    q_data.ply      = ply;
    // store keeps the wrapped adjusted score; probe does not use it
    q_data.score    = mode ? adj[15:0] : score_in;
    q_data.bound    = bound_kind;
    q_data.move     = move;
    q_data.alpha    = alpha;
    q_data.beta     = beta;
  end

endmodule

`default_nettype wire

@@ rtl/stt_back.sv @@
// ----------------------------------------------------------------------------
// stt_back
// Table memory, post-reset clear sweep, probe/store evaluation and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back #(
  parameter int unsigned ENTRY_COUNT = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [14:0]   mate_value,
  output logic               busy,
  input  wire logic          q_valid,
  input  wire stt_pkg::req_t q_data,
  output logic               q_rd,
  output logic               empty,
  input  wire logic          pop,
  output logic               hit,
  output logic [31:0]        hit_move,
  output logic               deep_enough,
  output logic [15:0]        probe_score,
  output logic               cutoff,
  output logic               wrote
);

  localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRY_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [stt_pkg::ENTRY_W-1:0] mem [ENTRY_COUNT];
  logic [stt_pkg::ENTRY_W-1:0] rd_word;
  logic [IDX_W-1:0]            rd_idx;
  logic [IDX_W-1:0]            wr_idx;
  logic [stt_pkg::ENTRY_W-1:0] wr_word;
  logic                        wr_en;
  logic [IDX_W-1:0]            clr_idx;

  stt_pkg::req_t  cur;
  stt_pkg::entry_t ent;
  stt_pkg::entry_t new_ent;

  logic               out_valid;
  logic               out_free;
  logic               eval_go;
  logic               st_wr;
  logic               pr_hit;
  logic               pr_deep;
  logic               pr_cut;
  logic signed [17:0] pr_s;

  assign busy     = (state == ST_CLEAR);
  assign q_rd     = (state == ST_IDLE) && q_valid;
  assign rd_idx   = q_data.key[IDX_W-1:0] & IDX_MASK;
  assign out_free = !out_valid || pop;
  assign eval_go  = (state == ST_EVAL) && out_free;
  assign empty    = !out_valid;

  assign ent = stt_pkg::entry_t'(rd_word);

  // evaluation on the slot read for the current request
  always_comb begin
    st_wr   = (ent.bound == stt_pkg::BOUND_NONE) || (ent.key == cur.key) ||
              (cur.depth >= ent.depth);
    pr_hit  = (ent.bound != stt_pkg::BOUND_NONE) && (ent.key == cur.key);
    pr_deep = pr_hit && (ent.depth >= cur.depth);
    pr_s    = stt_pkg::mate_adjust(ent.score, cur.ply, mate_value, 1'b0);
    pr_cut  = pr_deep &&
              ((ent.bound == stt_pkg::BOUND_EXACT) ||
               ((ent.bound == stt_pkg::BOUND_LOWER) && (pr_s >= 18'($signed(cur.beta)))) ||
               ((ent.bound == stt_pkg::BOUND_UPPER) && (pr_s <= 18'($signed(cur.alpha)))));
    new_ent.key   = cur.key;
    new_ent.move  = cur.move;
    new_ent.score = cur.score;
    new_ent.depth = cur.depth;
    new_ent.bound = cur.bound;
  end

  // memory write: clear sweep or accepted store
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = clr_idx;
    wr_word = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (eval_go && cur.is_store && st_wr) begin
      wr_en   = 1'b1;
      wr_idx  = cur.key[IDX_W-1:0] & IDX_MASK;
      wr_word = new_ent;
    end
  end

  // slot word is held for the whole evaluation, even while the result stalls
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    if (q_rd) begin
      rd_word <= mem[rd_idx];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == IDX_MASK) state_next = ST_IDLE;
      ST_IDLE:  if (q_valid) state_next = ST_EVAL;
      ST_EVAL:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (eval_go) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
    if (eval_go) begin
      if (cur.is_store) begin
        hit         <= 1'b0;
        hit_move    <= '0;
        deep_enough <= 1'b0;
        probe_score <= '0;
        cutoff      <= 1'b0;
        wrote       <= st_wr;
      end else begin
        hit         <= pr_hit;
        hit_move    <= pr_hit ? ent.move : '0;
        deep_enough <= pr_deep;
        probe_score <= pr_deep ? pr_s[15:0] : '0;
        cutoff      <= pr_cut;
        wrote       <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/search_transposition_table_core.sv @@
// ----------------------------------------------------------------------------
// search_transposition_table_core
// Depth-preferred direct-mapped transposition table, probe and store.
// ----------------------------------------------------------------------------
// Usage:
//  - Request side is a queue: present a request and raise push; it is taken
//    on a clock edge with push high and full low. mode 0 probes, mode 1
//    stores. Slot index is key & (ENTRY_COUNT-1).
//  - Result side is a queue: while empty is low the result ports hold the
//    oldest result; pop on an edge with empty low takes it. One result per
//    request, in request order.
//  - A request goes through the queue, the memory read and evaluation before
//    empty goes low. The next request is read only after the current one is
//    evaluated: read-then-evaluate/write on the single table memory port pair.
//  - The front end keeps accepting into a 2-deep queue while a result waits;
//    when pop stays low, the queue fills and full rises.
//  - Reset (rst, synchronous) starts a clear sweep over all ENTRY_COUNT slots,
//    one slot per cycle; full stays high until it ends. mate_value resets
//    to 32000; APB writes are taken at any time.
//  - APB: mate_value at byte address 0, 15 bits, pready always high.
// ----------------------------------------------------------------------------
`default_nettype none

module search_transposition_table_core #(
  parameter int unsigned ENTRY_COUNT = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [stt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // requests
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       mode,
  input  wire logic [63:0]                key,
  input  wire logic [6:0]                 depth,
  input  wire logic [7:0]                 ply,
  input  wire logic signed [15:0]         score_in,
  input  wire logic [1:0]                 bound_kind,
  input  wire logic [31:0]                move,
  input  wire logic signed [15:0]         alpha,
  input  wire logic signed [15:0]         beta,
  // results
  output logic                            empty,
  input  wire logic                       pop,
  output logic                            hit,
  output logic [31:0]                     hit_move,
  output logic                            deep_enough,
  output logic signed [15:0]              probe_score,
  output logic                            cutoff,
  output logic                            wrote
);

  logic [14:0]   mate_value;
  logic          busy;
  logic          q_full;
  logic          q_wr;
  logic          q_rd;
  logic          q_valid;
  stt_pkg::req_t q_in;
  stt_pkg::req_t q_out;
  logic [15:0]   probe_score_raw;

  // register file: a single register, selected by paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == stt_pkg::REG_MATE_VALUE) ? {17'd0, mate_value} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mate_value <= 15'(stt_pkg::MATE_RESET);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == stt_pkg::REG_MATE_VALUE)) begin
      mate_value <= pwdata[14:0];
    end
  end

  stt_front u_front (
    .push       (push),
    .full       (full),
    .mode       (mode),
    .key        (key),
    .depth      (depth),
    .ply        (ply),
    .score_in   (score_in),
    .bound_kind (bound_kind),
    .move       (move),
    .alpha      (alpha),
    .beta       (beta),
    .mate_value (mate_value),
    .busy       (busy),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_data     (q_in)
  );

  stt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_wr),
    .wr_data   (q_in),
    .full      (q_full),
    .rd_en     (q_rd),
    .not_empty (q_valid),
    .rd_data   (q_out)
  );

  stt_back #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mate_value  (mate_value),
    .busy        (busy),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .hit         (hit),
    .hit_move    (hit_move),
    .deep_enough (deep_enough),
    .probe_score (probe_score_raw),
    .cutoff      (cutoff),
    .wrote       (wrote)
  );

  assign probe_score = $signed(probe_score_raw);

endmodule

`default_nettype wire
